/* rtl/bmpu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpu_pkg
// shared constants and types of the bmp scanline pixel unpacker
// ----------------------------------------------------------------------------
package bmpu_pkg;

	// colour table
	localparam int PAL_ENTRIES = 256;
	localparam int PAL_AW      = $clog2(PAL_ENTRIES);
	localparam int RGB_W       = 24;

	// row position
	localparam int COL_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;

	// pixel formats
	localparam logic [2:0] FMT_1BPP  = 3'd0;
	localparam logic [2:0] FMT_4BPP  = 3'd1;
	localparam logic [2:0] FMT_8BPP  = 3'd2;
	localparam logic [2:0] FMT_16BPP = 3'd3;
	localparam logic [2:0] FMT_24BPP = 3'd4;
	localparam logic [2:0] FMT_32BPP = 3'd5;

	// item opcodes
	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_DATA    = 1'b1;

	// one pixel on its way to the output register
	typedef struct packed {
		logic             use_pal;
		logic [RGB_W-1:0] rgb;
		logic [COL_W-1:0] column;
		logic             row_end;
		logic             run_last;
	} pix_t;

endpackage
`default_nettype wire

/* rtl/bmpu_palette_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpu_palette_ram
// simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
module bmpu_palette_ram #(
	parameter int DEPTH  = 256,
	parameter int DATA_W = 24,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire              clk,
	input  wire              we,
	input  wire [AW-1:0]     waddr,
	input  wire [DATA_W-1:0] wdata,
	input  wire              re,
	input  wire [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

/* rtl/bmpu_unpack.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmpu_unpack
// holds one item, turns data bytes into pixels at most one per cycle, keeps
// the row position and issues palette writes and lookups to the colour table
// ----------------------------------------------------------------------------
module bmpu_unpack
	import bmpu_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	// item in
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   op,
	input  wire  [7:0]            data_byte,
	input  wire  [7:0]            palette_index,
	input  wire  [7:0]            palette_red,
	input  wire  [7:0]            palette_green,
	input  wire  [7:0]            palette_blue,
	// configuration
	input  wire                   cfg_we,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data,
	// pixel out
	input  wire                   adv,
	output logic                  pix_fire,
	output pix_t                  pix,
	// colour table
	output logic                  pal_we,
	output logic [PAL_AW-1:0]     pal_waddr,
	output logic [RGB_W-1:0]      pal_wdata,
	output logic                  pal_re,
	output logic [PAL_AW-1:0]     pal_raddr
);

	// held item
	logic             hold_valid_q;
	logic             op_q;
	logic [7:0]       byte_q;
	logic [7:0]       pidx_q;
	logic [RGB_W-1:0] pcol_q;
	logic [2:0]       sub_q;

	// configuration and row state
	logic [2:0]       fmt_q;
	logic [COL_W-1:0] width_q;
	logic [COL_W-1:0] col_q;
	logic [1:0]       bp_q;
	logic [RGB_W-1:0] partial_q;
	logic [1:0]       rbp_q;
	logic             pad_q;

	logic [COL_W-1:0] col_d;
	logic [1:0]       bp_d;
	logic [RGB_W-1:0] partial_d;
	logic [1:0]       rbp_d;
	logic             pad_d;
	logic [2:0]       sub_d;

	logic [COL_W-1:0] width_eff;
	logic [COL_W:0]   col_inc;
	logic             last;
	logic [1:0]       rbp_next;
	logic             is_data;
	logic             fmt_ok;
	logic             emit_want;
	logic             done;
	logic             step;
	logic             consume;
	logic [7:0]       idx;
	logic             lookup;
	logic [RGB_W-1:0] direct_rgb;
	logic [RGB_W-1:0] partial_mod;
	logic [1:0]       last_phase;
	logic [15:0]      word;
	logic             cfg_hit;

	assign width_eff = (width_q == '0) ? COL_W'(1) : width_q;
	assign col_inc   = {1'b0, col_q} + (COL_W+1)'(1);
	assign last      = col_inc >= {1'b0, width_eff};
	assign rbp_next  = rbp_q + 2'd1;
	assign is_data   = op_q == OP_DATA;
	assign fmt_ok    = fmt_q <= FMT_32BPP;
	assign word      = {byte_q, partial_q[7:0]};

	assign last_phase = (fmt_q == FMT_24BPP) ? 2'd2 : 2'd3;

	always_comb begin
		case (bp_q)
			2'd0:    partial_mod = {partial_q[23:8], byte_q};
			2'd1:    partial_mod = {partial_q[23:16], byte_q, partial_q[7:0]};
			2'd2:    partial_mod = {byte_q, partial_q[15:0]};
			default: partial_mod = partial_q;
		endcase
	end

	// what the held item wants this cycle
	always_comb begin
		emit_want  = 1'b0;
		done       = 1'b1;
		lookup     = 1'b0;
		idx        = byte_q;
		direct_rgb = '0;
		if (is_data && fmt_ok && !pad_q) begin
			case (fmt_q)
				FMT_1BPP: begin
					emit_want = 1'b1;
					lookup    = 1'b1;
					idx       = {7'd0, byte_q[3'd7 - sub_q]};
					done      = last || (sub_q == 3'd7);
				end
				FMT_4BPP: begin
					emit_want = 1'b1;
					lookup    = 1'b1;
					idx       = sub_q[0] ? {4'd0, byte_q[3:0]} : {4'd0, byte_q[7:4]};
					done      = last || sub_q[0];
				end
				FMT_8BPP: begin
					emit_want = 1'b1;
					lookup    = 1'b1;
				end
				FMT_16BPP: begin
					emit_want  = bp_q != 2'd0;
					direct_rgb = {word[14:10], 3'd0, word[9:5], 3'd0, word[4:0], 3'd0};
				end
				default: begin
					emit_want  = bp_q >= last_phase;
					direct_rgb = partial_mod;
				end
			endcase
		end
	end

	assign step     = hold_valid_q && (!emit_want || adv);
	assign consume  = step && done;
	assign pix_fire = step && emit_want;
	assign in_ready = !hold_valid_q || consume;

	// a lookup past the table gives black
	always_comb begin
		pix.use_pal  = lookup && (int'(idx) < PAL_ENTRIES);
		pix.rgb      = lookup ? '0 : direct_rgb;
		pix.column   = col_q;
		pix.row_end  = last;
		pix.run_last = done;
	end

	assign pal_re    = pix_fire && pix.use_pal;
	assign pal_raddr = idx[PAL_AW-1:0];
	assign pal_we    = step && !is_data && (int'(pidx_q) < PAL_ENTRIES);
	assign pal_waddr = pidx_q[PAL_AW-1:0];
	assign pal_wdata = pcol_q;

	// next row state
	always_comb begin
		col_d     = col_q;
		bp_d      = bp_q;
		partial_d = partial_q;
		rbp_d     = rbp_q;
		pad_d     = pad_q;
		sub_d     = sub_q;
		if (step && is_data && fmt_ok) begin
			if (consume) begin
				rbp_d = rbp_next;
			end
			if (pad_q) begin
				if (rbp_next == 2'd0) begin
					pad_d = 1'b0;
				end
			end else begin
				if (fmt_q == FMT_16BPP) begin
					if (bp_q == 2'd0) begin
						partial_d = {16'd0, byte_q};
						bp_d      = 2'd1;
					end else begin
						partial_d = '0;
						bp_d      = 2'd0;
					end
				end else if (fmt_q == FMT_24BPP || fmt_q == FMT_32BPP) begin
					if (emit_want) begin
						partial_d = '0;
						bp_d      = 2'd0;
					end else begin
						partial_d = partial_mod;
						bp_d      = bp_q + 2'd1;
					end
				end
				if (emit_want) begin
					if (last) begin
						col_d     = '0;
						bp_d      = 2'd0;
						partial_d = '0;
						if (rbp_next != 2'd0) begin
							pad_d = 1'b1;
						end
					end else begin
						col_d = col_inc[COL_W-1:0];
					end
				end
			end
		end
		if (consume) begin
			sub_d = 3'd0;
		end else if (step) begin
			sub_d = sub_q + 3'd1;
		end
	end

	assign cfg_hit = cfg_we && (cfg_index == CFG_FORMAT || cfg_index == CFG_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			sub_q        <= 3'd0;
			fmt_q        <= FMT_8BPP;
			width_q      <= COL_W'(1);
			col_q        <= '0;
			bp_q         <= 2'd0;
			partial_q    <= '0;
			rbp_q        <= 2'd0;
			pad_q        <= 1'b0;
		end else begin
			if (in_ready) begin
				hold_valid_q <= in_valid;
			end
			if (cfg_hit) begin
				if (cfg_index == CFG_FORMAT) begin
					fmt_q <= cfg_data[2:0];
				end else begin
					width_q <= cfg_data[COL_W-1:0];
				end
				// a write to the format or width register restarts the row
				col_q     <= '0;
				bp_q      <= 2'd0;
				partial_q <= '0;
				rbp_q     <= 2'd0;
				pad_q     <= 1'b0;
				sub_q     <= 3'd0;
			end else begin
				col_q     <= col_d;
				bp_q      <= bp_d;
				partial_q <= partial_d;
				rbp_q     <= rbp_d;
				pad_q     <= pad_d;
				sub_q     <= sub_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_q   <= op;
			byte_q <= data_byte;
			pidx_q <= palette_index;
			pcol_q <= {palette_red, palette_green, palette_blue};
		end
	end

endmodule
`default_nettype wire

/* rtl/bmp_scanline_pixel_unpacker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_scanline_pixel_unpacker
// turns raw bytes of uncompressed bmp rows into rgb pixels, with a colour
// table for the indexed formats
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    op, data_byte, palette_*
// out       output     out_valid / out_ready  red, green, blue, column,
//                                             row_end, run_last
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// unless the output stalls: one item per cycle for 8, 16, 24 and 32 bpp and
// for palette writes; a 1 bpp byte gives up to 8 pixels and a 4 bpp byte up
// to 2, one pixel per cycle, set by the single read port of the colour table.
// out_valid is registered via the item register and then the output register.
// in a stall the item register takes a new item only when empty or holding an
// item without a pixel. reset clears control state; the colour table is not
// cleared and must be written before it is looked up.
// ----------------------------------------------------------------------------
module bmp_scanline_pixel_unpacker
	import bmpu_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire                   op,
	input  wire  [7:0]            data_byte,
	input  wire  [7:0]            palette_index,
	input  wire  [7:0]            palette_red,
	input  wire  [7:0]            palette_green,
	input  wire  [7:0]            palette_blue,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	output logic [COL_W-1:0]      column,
	output logic                  row_end,
	output logic                  run_last,
	input  wire                   cfg_we,
	input  wire  [CFG_IDX_W-1:0]  cfg_index,
	input  wire  [CFG_DATA_W-1:0] cfg_data
);

	logic              adv;
	logic              pix_fire;
	pix_t              pix;
	logic              pal_we;
	logic [PAL_AW-1:0] pal_waddr;
	logic [RGB_W-1:0]  pal_wdata;
	logic              pal_re;
	logic [PAL_AW-1:0] pal_raddr;
	logic [RGB_W-1:0]  pal_rdata;

	logic              valid_s2;
	pix_t              pix_s2;
	logic [RGB_W-1:0]  rgb;

	assign adv = !valid_s2 || out_ready;

	bmpu_unpack u_unpack (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.data_byte     (data_byte),
		.palette_index (palette_index),
		.palette_red   (palette_red),
		.palette_green (palette_green),
		.palette_blue  (palette_blue),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.adv           (adv),
		.pix_fire      (pix_fire),
		.pix           (pix),
		.pal_we        (pal_we),
		.pal_waddr     (pal_waddr),
		.pal_wdata     (pal_wdata),
		.pal_re        (pal_re),
		.pal_raddr     (pal_raddr)
	);

	bmpu_palette_ram #(
		.DEPTH  (PAL_ENTRIES),
		.DATA_W (RGB_W)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.re    (pal_re),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	// output register, lines up with the table read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= pix_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && pix_fire) begin
			pix_s2 <= pix;
		end
	end

	assign rgb       = pix_s2.use_pal ? pal_rdata : pix_s2.rgb;
	assign out_valid = valid_s2;
	assign red       = rgb[23:16];
	assign green     = rgb[15:8];
	assign blue      = rgb[7:0];
	assign column    = pix_s2.column;
	assign row_end   = pix_s2.row_end;
	assign run_last  = pix_s2.run_last;

endmodule
`default_nettype wire
